/* hdl/sff_pkg.sv */
// Package for the scanline flood fill: sizes, codes and state encoding.
// No dependencies.
`timescale 1ns / 1ps
package sff_pkg;
   localparam int MaxWidth   = 64;
   localparam int MaxHeight  = 64;
   localparam int StackDepth = 1024;
   localparam int PixelBits  = 8;
   localparam int XBits      = $clog2(MaxWidth);
   localparam int YBits      = $clog2(MaxHeight);
   localparam int ABits      = XBits + YBits;
   localparam int SBits      = $clog2(StackDepth);

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_FILL  = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NOCHANGE = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_COLOR  = 2'd2
   } csr_type;

   typedef enum logic [3:0] {
      S_IDLE, S_ACCESS, S_RDATA, S_SEED, S_POP, S_POPDATA, S_CHECK,
      S_LEFT, S_LEFTCHK, S_RIGHT, S_RIGHTCHK, S_PAINT, S_SCAN, S_SCANCHK,
      S_RESP
   } state_type;
endpackage

/* hdl/scanline_flood_fill.sv */
// Top level of the scanline flood fill: image memory, seed stack and sequencer.
// Depends on sff_pkg and sff_ram.
`timescale 1ns / 1ps
// Usage:
//  - Commands enter on req_* when start is high and busy is low. action 0
//    writes a pixel, 2 reads one, 1 floods the region around (pos_x, pos_y)
//    with the configured color. One command is in flight at a time.
//  - Every command produces exactly one result on rsp_*, marked by
//    rsp_valid for one cycle. The receiver cannot stall; it must take it.
//  - A write, an unused action or a command outside the active area goes
//    from S_ACCESS straight to S_RESP; a read inside the area passes
//    through S_RDATA first (one image memory read). Busy drops after
//    the result, and the next command is accepted once busy is low.
//  - A fill reads the seed, then per run: extends it left and right one
//    pixel at a time, reading and checking each, paints every pixel of
//    the run and scans each neighbor row pixel by pixel; every stacked
//    seed is popped and checked. A last pop and the result end the fill.
//  - Configuration transfers on csr_* are always accepted (csr_ready high);
//    write them only while idle.
//  - Reset clears control state and loads width 32, height 32, color 2. The
//    image memory is undefined until written; there is no clearing pass.
module scanline_flood_fill (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_action,
   input  logic [5:0]                    req_pos_x,
   input  logic [5:0]                    req_pos_y,
   input  logic [7:0]                    req_pixel_in,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_pixel_out,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [7:0]                    csr_data
);
   import sff_pkg::*;

   // configuration
   logic [6:0] width_ff, height_ff;
   logic [7:0] color_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 7'd32;
         height_ff <= 7'd32;
         color_ff  <= 8'd2;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_data[6:0];
            CSR_HEIGHT: height_ff <= csr_data[6:0];
            CSR_COLOR:  color_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // active size clamped to the stored image
   logic [6:0] aw, ah;
   assign aw = (width_ff  > 7'(MaxWidth))  ? 7'(MaxWidth)  : width_ff;
   assign ah = (height_ff > 7'(MaxHeight)) ? 7'(MaxHeight) : height_ff;

   // control and working registers
   state_type state_ff, state_in;
   action_type act_ff;
   logic [XBits-1:0] x_ff, x1_ff, x2_ff, i_ff;
   logic [YBits-1:0] y_ff, sy_ff;
   logic [PixelBits-1:0] pin_ff, color_match_ff;
   logic [SBits:0] sp_ff;
   logic ovf_ff, run_ff, pass_ff;
   status_type status_ff;
   logic [7:0] pout_ff;

   // memories
   logic img_we, stk_we;
   logic [ABits-1:0] img_addr;
   logic [PixelBits-1:0] img_wdata, img_rdata;
   logic [SBits-1:0] stk_addr;
   logic [XBits+YBits-1:0] stk_wdata, stk_rdata;

   sff_ram #(.Width(PixelBits), .Depth(MaxWidth*MaxHeight)) u_img (
      .clock(clock), .we(img_we), .addr(img_addr), .wdata(img_wdata),
      .rdata(img_rdata));
   sff_ram #(.Width(XBits+YBits), .Depth(StackDepth)) u_stk (
      .clock(clock), .we(stk_we), .addr(stk_addr), .wdata(stk_wdata),
      .rdata(stk_rdata));

   logic in_area;
   assign in_area = ({1'b0, x_ff} < aw) && ({1'b0, y_ff} < ah);
   logic match;
   assign match = img_rdata == color_match_ff;
   logic [PixelBits-1:0] paint;
   assign paint = color_ff[PixelBits-1:0];

   // neighbor rows: pass 0 scans above, pass 1 below
   logic up_ok, dn_ok;
   assign up_ok = y_ff != '0;
   assign dn_ok = ({1'b0, y_ff} + 7'd1) < ah;

   // right end of the run reached the last active column
   logic right_end;
   assign right_end = ({1'b0, x2_ff} + 7'd1) >= aw;

   // first pixel of a run in the scanned row, and room left on the stack
   logic seed_hit, stk_room;
   assign seed_hit = match && !run_ff;
   assign stk_room = sp_ff < (SBits+1)'(StackDepth);

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_ACCESS;
         end
         S_ACCESS: begin
            if (in_area && act_ff == ACT_READ) state_in = S_RDATA;
            else if (in_area && act_ff == ACT_FILL) state_in = S_SEED;
            else state_in = S_RESP;
         end
         S_RDATA:    state_in = S_RESP;
         S_SEED:     state_in = (img_rdata == paint) ? S_RESP : S_LEFT;
         S_POP:      state_in = (sp_ff == '0) ? S_RESP : S_POPDATA;
         S_POPDATA:  state_in = S_CHECK;
         S_CHECK:    state_in = (in_area && match) ? S_LEFT : S_POP;
         S_LEFT:     state_in = (x1_ff == '0) ? S_RIGHT : S_LEFTCHK;
         S_LEFTCHK:  state_in = match ? S_LEFT : S_RIGHT;
         S_RIGHT:    state_in = right_end ? S_PAINT : S_RIGHTCHK;
         S_RIGHTCHK: state_in = match ? S_RIGHT : S_PAINT;
         S_PAINT: begin
            if (i_ff == x2_ff) state_in = (up_ok || dn_ok) ? S_SCAN : S_POP;
         end
         S_SCAN:     state_in = S_SCANCHK;
         S_SCANCHK: begin
            if (i_ff == x2_ff && (pass_ff || !dn_ok)) state_in = S_POP;
            else state_in = S_SCAN;
         end
         S_RESP:     state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // memory port control
   always_comb begin
      img_we    = 1'b0;
      img_addr  = {y_ff, x_ff};
      img_wdata = pin_ff;
      stk_we    = 1'b0;
      stk_addr  = sp_ff[SBits-1:0];
      stk_wdata = {sy_ff, i_ff};
      unique case (state_ff)
         S_ACCESS:  img_we = (act_ff == ACT_WRITE) && in_area;
         S_POP:     stk_addr = sp_ff[SBits-1:0] - SBits'(1);
         S_POPDATA: img_addr = stk_rdata;
         S_LEFT:    img_addr = {y_ff, x1_ff - XBits'(1)};
         S_RIGHT:   img_addr = {y_ff, x2_ff + XBits'(1)};
         S_PAINT: begin
            img_addr  = {y_ff, i_ff};
            img_wdata = paint;
            img_we    = 1'b1;
         end
         S_SCAN:    img_addr = {sy_ff, i_ff};
         S_SCANCHK: stk_we = seed_hit && stk_room;
         default: ;
      endcase
   end

   // state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  act_ff    <= action_type'(req_action);
                  x_ff      <= req_pos_x;
                  y_ff      <= req_pos_y;
                  pin_ff    <= req_pixel_in;
                  pout_ff   <= '0;
                  status_ff <= ST_DONE;
               end
            end
            S_ACCESS: begin
               if (act_ff == ACT_FILL && !in_area) status_ff <= ST_NOCHANGE;
            end
            S_RDATA: pout_ff <= img_rdata;
            S_SEED: begin
               // the seed is its own first run; no push needed
               color_match_ff <= img_rdata;
               x1_ff  <= x_ff;
               x2_ff  <= x_ff;
               sp_ff  <= '0;
               ovf_ff <= 1'b0;
               if (img_rdata == paint) status_ff <= ST_NOCHANGE;
            end
            S_POP: begin
               if (sp_ff == '0) begin
                  status_ff <= ovf_ff ? ST_OVERFLOW : ST_DONE;
               end else begin
                  sp_ff <= sp_ff - (SBits+1)'(1);
               end
            end
            S_POPDATA: begin
               x_ff <= stk_rdata[XBits-1:0];
               y_ff <= stk_rdata[ABits-1:XBits];
            end
            S_CHECK: begin
               x1_ff <= x_ff;
               x2_ff <= x_ff;
            end
            S_LEFTCHK: begin
               if (match) x1_ff <= x1_ff - XBits'(1);
            end
            S_RIGHT: begin
               if (right_end) i_ff <= x1_ff;
            end
            S_RIGHTCHK: begin
               if (match) x2_ff <= x2_ff + XBits'(1);
               else i_ff <= x1_ff;
            end
            S_PAINT: begin
               if (i_ff == x2_ff) begin
                  i_ff   <= x1_ff;
                  run_ff <= 1'b0;
                  if (up_ok) begin
                     sy_ff   <= y_ff - YBits'(1);
                     pass_ff <= 1'b0;
                  end else begin
                     sy_ff   <= y_ff + YBits'(1);
                     pass_ff <= 1'b1;
                  end
               end else begin
                  i_ff <= i_ff + XBits'(1);
               end
            end
            S_SCANCHK: begin
               // push the first pixel of each matching run, drop it when full
               if (seed_hit) begin
                  if (stk_room) sp_ff <= sp_ff + (SBits+1)'(1);
                  else ovf_ff <= 1'b1;
               end
               if (i_ff == x2_ff) begin
                  i_ff    <= x1_ff;
                  run_ff  <= 1'b0;
                  sy_ff   <= y_ff + YBits'(1);
                  pass_ff <= 1'b1;
               end else begin
                  i_ff   <= i_ff + XBits'(1);
                  run_ff <= match;
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_pixel_out = pout_ff;
   assign rsp_status    = status_ff;
endmodule

/* hdl/sff_ram.sv */
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sff_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
